>>> rtl/olst_pkg.sv
`timescale 1ns / 1ps

package olst_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } olst_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } olst_status_e;

  // read address source for the entry memory
  typedef enum logic [1:0] {
    RA_POS     = 2'd0,
    RA_PTR     = 2'd1,
    RA_PTR_DEC = 2'd2,
    RA_PTR_INC = 2'd3
  } olst_ra_e;

  typedef struct packed {
    logic         start;
    logic         ptr_ld_cnt;
    logic         ptr_ld_p0;
    logic         ptr_clr;
    logic         ptr_inc;
    logic         ptr_dec;
    olst_ra_e     ra_sel;
    logic         mv;
    logic         cap;
    logic         cmp;
    logic         wr_val;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         set_st;
    olst_status_e st;
    logic         set_found;
    logic         load_out;
  } olst_cmd_t;

  typedef struct packed {
    olst_op_e op;
    logic     ins_bad;
    logic     full;
    logic     pos_bad;
    logic     ins_more;
    logic     del_more;
    logic     loc_more;
    logic     hit;
  } olst_stat_t;

endpackage

>>> rtl/olst_req_if.sv
`timescale 1ns / 1ps

interface olst_req_if;
  logic                                valid;
  logic                                ready;
  logic        [olst_pkg::CMD_W-1:0]   command;
  logic        [olst_pkg::POS_W-1:0]   position;
  logic signed [olst_pkg::VAL_W-1:0]   value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

>>> rtl/olst_rsp_if.sv
`timescale 1ns / 1ps

interface olst_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [olst_pkg::ST_W-1:0]     status;
  logic signed [olst_pkg::VAL_W-1:0]    read_value;
  logic        [olst_pkg::CNT_OUT_W-1:0] found_position;
  logic        [olst_pkg::CNT_OUT_W-1:0] count;

  modport source (output valid, output status, output read_value, output found_position,
                  output count, input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input count, output ready);
endinterface

>>> rtl/olst_ram.sv
`timescale 1ns / 1ps

module olst_ram #(
  parameter int unsigned WIDTH = olst_pkg::VAL_W,
  parameter int unsigned DEPTH = olst_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/olst_datapath.sv
`timescale 1ns / 1ps

module olst_datapath #(
  parameter int unsigned DEPTH = olst_pkg::DEPTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  olst_pkg::olst_cmd_t                     cmd_i,
  output olst_pkg::olst_stat_t                    stat_o,
  input  logic        [olst_pkg::CMD_W-1:0]       req_command_i,
  input  logic        [olst_pkg::POS_W-1:0]       req_position_i,
  input  logic signed [olst_pkg::VAL_W-1:0]       req_value_i,
  output logic        [olst_pkg::ST_W-1:0]        rsp_status_o,
  output logic signed [olst_pkg::VAL_W-1:0]       rsp_read_value_o,
  output logic        [olst_pkg::CNT_OUT_W-1:0]   rsp_found_position_o,
  output logic        [olst_pkg::CNT_OUT_W-1:0]   rsp_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = ((CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W) + 1;
  localparam int unsigned VW = olst_pkg::VAL_W;

  olst_pkg::olst_op_e           op_q;
  logic [olst_pkg::POS_W-1:0]   pos_q;
  logic [VW-1:0]                val_q;
  logic [CW-1:0]                count_q;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                ra_q;
  logic [AW-1:0]                wa_q;
  logic                         pend_q, cap_q, cmp_q;
  olst_pkg::olst_status_e       res_st_q;
  logic [VW-1:0]                res_val_q;
  logic [olst_pkg::CNT_OUT_W-1:0] res_found_q;

  logic [XW-1:0] pos_x, cnt_x, ptr_x, p0_x, ra_x, found_x;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [VW-1:0] wdata, rdata;

  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(count_q);
  assign ptr_x   = XW'(ptr_q);
  assign p0_x    = pos_x - XW'(1);
  assign found_x = XW'(ra_q) + XW'(1);

  assign stat_o.op       = op_q;
  assign stat_o.ins_bad  = (pos_q == '0) || (pos_x > cnt_x + XW'(1));
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.pos_bad  = (pos_q == '0) || (pos_x > cnt_x);
  assign stat_o.ins_more = (ptr_x > p0_x);
  assign stat_o.del_more = (ptr_x + XW'(1) < cnt_x);
  assign stat_o.loc_more = (ptr_x < cnt_x);
  assign stat_o.hit      = cmp_q && (rdata == val_q);

  always_comb begin
    unique case (cmd_i.ra_sel)
      olst_pkg::RA_POS:     ra_x = p0_x;
      olst_pkg::RA_PTR:     ra_x = ptr_x;
      olst_pkg::RA_PTR_DEC: ra_x = ptr_x - XW'(1);
      olst_pkg::RA_PTR_INC: ra_x = ptr_x + XW'(1);
      default:              ra_x = ptr_x;
    endcase
  end

  assign raddr = ra_x[AW-1:0];
  // a pending move writes the word read in the previous cycle
  assign we    = pend_q | cmd_i.wr_val;
  assign waddr = cmd_i.wr_val ? p0_x[AW-1:0] : wa_q;
  assign wdata = cmd_i.wr_val ? val_q : rdata;

  olst_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_ld_cnt) begin
      ptr_d = count_q;
    end else if (cmd_i.ptr_ld_p0) begin
      ptr_d = p0_x[CW-1:0];
    end else if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      cap_q   <= 1'b0;
      cmp_q   <= 1'b0;
    end else begin
      pend_q <= cmd_i.mv;
      cap_q  <= cmd_i.cap;
      cmp_q  <= cmd_i.cmp;
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.mv) begin
      wa_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.cmp) begin
      ra_q <= ptr_q;
    end
    if (cmd_i.start) begin
      op_q        <= olst_pkg::olst_op_e'(req_command_i);
      pos_q       <= req_position_i;
      val_q       <= req_value_i;
      res_st_q    <= olst_pkg::ST_OK;
      res_val_q   <= '0;
      res_found_q <= '0;
    end else begin
      if (cmd_i.set_st) begin
        res_st_q <= cmd_i.st;
      end
      if (cap_q) begin
        res_val_q <= rdata;
      end
      if (cmd_i.set_found) begin
        res_found_q <= found_x[olst_pkg::CNT_OUT_W-1:0];
      end
    end
    if (cmd_i.load_out) begin
      rsp_status_o         <= res_st_q;
      rsp_read_value_o     <= res_val_q;
      rsp_found_position_o <= res_found_q;
      rsp_count_o          <= cnt_x[olst_pkg::CNT_OUT_W-1:0];
    end
  end

endmodule

>>> rtl/olst_ctrl.sv
`timescale 1ns / 1ps

module olst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  olst_pkg::olst_stat_t stat_i,
  output olst_pkg::olst_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CHECK     = 8'b0000_0010,
    S_INS_SHIFT = 8'b0000_0100,
    S_INS_PUT   = 8'b0000_1000,
    S_DEL_SHIFT = 8'b0001_0000,
    S_GET_WAIT  = 8'b0010_0000,
    S_LOC_SCAN  = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } olst_state_e;

  olst_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat_i.op)
          olst_pkg::OP_INSERT: begin
            if (stat_i.ins_bad) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = olst_pkg::ST_RANGE;
              state_d      = S_FINISH;
            end else if (stat_i.full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = olst_pkg::ST_FULL;
              state_d      = S_FINISH;
            end else begin
              cmd_o.ptr_ld_cnt = 1'b1;
              state_d          = S_INS_SHIFT;
            end
          end
          olst_pkg::OP_DELETE: begin
            if (stat_i.pos_bad) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = olst_pkg::ST_RANGE;
              state_d      = S_FINISH;
            end else begin
              cmd_o.ra_sel    = olst_pkg::RA_POS;
              cmd_o.cap       = 1'b1;
              cmd_o.ptr_ld_p0 = 1'b1;
              state_d         = S_DEL_SHIFT;
            end
          end
          olst_pkg::OP_GET: begin
            if (stat_i.pos_bad) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = olst_pkg::ST_RANGE;
              state_d      = S_FINISH;
            end else begin
              cmd_o.ra_sel = olst_pkg::RA_POS;
              cmd_o.cap    = 1'b1;
              state_d      = S_GET_WAIT;
            end
          end
          olst_pkg::OP_LOCATE: begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_LOC_SCAN;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_INS_SHIFT: begin
        // walk down from the tail, each word moves one place up
        if (stat_i.ins_more) begin
          cmd_o.ra_sel  = olst_pkg::RA_PTR_DEC;
          cmd_o.mv      = 1'b1;
          cmd_o.ptr_dec = 1'b1;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FINISH;
      end
      S_DEL_SHIFT: begin
        if (stat_i.del_more) begin
          cmd_o.ra_sel  = olst_pkg::RA_PTR_INC;
          cmd_o.mv      = 1'b1;
          cmd_o.ptr_inc = 1'b1;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_GET_WAIT: begin
        state_d = S_FINISH;
      end
      S_LOC_SCAN: begin
        // compare of the previous read overlaps the next read
        if (stat_i.hit) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FINISH;
        end else if (stat_i.loc_more) begin
          cmd_o.ra_sel  = olst_pkg::RA_PTR;
          cmd_o.cmp     = 1'b1;
          cmd_o.ptr_inc = 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/ordered_array_list_engine.sv
`timescale 1ns / 1ps
// insert shifts the tail up and writes at position p, delete shifts down over p,
// get reads position p (1-based), locate scans from the head; errors skip the work
// one request at a time, bounded by the single read port of the entry memory
// a finished response waits in the output register while the next request is taken
// async active-low reset clears the count and control; entries are not cleared

module ordered_array_list_engine #(
  parameter int unsigned DEPTH = olst_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  olst_req_if.sink          req_i,
  olst_rsp_if.source        rsp_o
);

  olst_pkg::olst_cmd_t  cmd;
  olst_pkg::olst_stat_t stat;

  olst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  olst_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .req_command_i        (req_i.command),
    .req_position_i       (req_i.position),
    .req_value_i          (req_i.value),
    .rsp_status_o         (rsp_o.status),
    .rsp_read_value_o     (rsp_o.read_value),
    .rsp_found_position_o (rsp_o.found_position),
    .rsp_count_o          (rsp_o.count)
  );

endmodule
